// ===== design/fdes_pkg.sv =====
// ----------------------------------------------------------------------------
// fdes_pkg: shared types and constants of the FAT directory entry scanner
// Entry and result word layouts, entry kinds and the name checksum step.
// ----------------------------------------------------------------------------
package fdes_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int POS_W          = 16;
  localparam int IN_DATA_W      = 136;
  localparam int OUT_DATA_W     = 80;
  localparam int KIND_W         = 3;

  localparam logic [7:0] FREE_MARK   = 8'hE5;
  localparam logic [7:0] LFN_MASK    = 8'h3F;
  localparam logic [7:0] LFN_ATTR    = 8'h0F;
  localparam logic [7:0] VOLUME_ATTR = 8'h08;
  localparam int         ORD_FIRST_BIT    = 6;
  localparam int         DIR_BIT          = 4;
  localparam int         SHORT_NAME_BYTES = 11;
  localparam int         HEAD_BYTES       = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_END       = 3'd0,
    KIND_FREE      = 3'd1,
    KIND_FRAG_KEPT = 3'd2,
    KIND_FRAG_DROP = 3'd3,
    KIND_VOLUME    = 3'd4,
    KIND_FILE      = 3'd5,
    KIND_DIR       = 3'd6
  } kind_t;

  // One directory entry held in the input stage, with the checksum
  // already run over the leading name bytes.
  typedef struct packed {
    logic [63:0] name_lo;
    logic [23:0] name_hi;
    logic [7:0]  attr;
    logic [7:0]  long_cksum;
    logic [15:0] clus_hi;
    logic [15:0] clus_lo;
    logic [7:0]  head_sum;
  } entry_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] position;
    logic [31:0]      first_cluster;
    logic             name_valid;
    logic             name_orphaned;
    logic [POS_W-1:0] chain_start;
    logic [5:0]       ordinal;
    logic [7:0]       name_sum;
  } result_t;

  // Rotate right by one, then add the next name byte.
  function automatic logic [7:0] sum_step(input logic [7:0] sum, input logic [7:0] b);
    sum_step = {sum[0], sum[7:1]} + b;
  endfunction

endpackage

// ===== design/fdes_input_stage.sv =====
// ----------------------------------------------------------------------------
// fdes_input_stage: input register of the scanner
// Unpacks the slave word, runs the checksum over the first name bytes and
// holds the entry until the classifier takes it.
// ----------------------------------------------------------------------------
module fdes_input_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [fdes_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          take,
  output logic                          entry_valid,
  output fdes_pkg::entry_t              entry
);
  import fdes_pkg::*;

  entry_t     entry_next;
  logic [7:0] head_sum;

  always_comb begin
    head_sum = 8'h00;
    for (int i = 0; i < HEAD_BYTES; i++) begin
      head_sum = sum_step(head_sum, s_axis_tdata[8*i +: 8]);
    end
    entry_next.name_lo    = s_axis_tdata[63:0];
    entry_next.name_hi    = s_axis_tdata[87:64];
    entry_next.attr       = s_axis_tdata[95:88];
    entry_next.long_cksum = s_axis_tdata[103:96];
    entry_next.clus_hi    = s_axis_tdata[119:104];
    entry_next.clus_lo    = s_axis_tdata[135:120];
    entry_next.head_sum   = head_sum;
  end

  assign s_axis_tready = !entry_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (s_axis_tready) begin
      entry_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      entry <= entry_next;
    end
  end

endmodule

// ===== design/fdes_classifier.sv =====
// ----------------------------------------------------------------------------
// fdes_classifier: entry decode and long-name chain tracking
// Classifies the held entry, finishes the name checksum and updates the
// chain state and the running entry index when the entry moves on.
// ----------------------------------------------------------------------------
module fdes_classifier #(
  parameter int INDEX_BITS = fdes_pkg::INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  fdes_pkg::entry_t  entry,
  input  logic              take,
  output fdes_pkg::result_t result
);
  import fdes_pkg::*;

  logic                  chain_pending, chain_pending_next;
  logic [7:0]            chain_checksum, chain_checksum_next;
  logic [INDEX_BITS-1:0] chain_start, chain_start_next;
  logic [INDEX_BITS-1:0] entry_counter, entry_counter_next;

  logic [7:0]  b0;
  logic [7:0]  sum;
  logic [87:0] name_bytes;

  assign b0         = entry.name_lo[7:0];
  assign name_bytes = {entry.name_hi, entry.name_lo};

  always_comb begin
    sum = entry.head_sum;
    for (int i = HEAD_BYTES; i < SHORT_NAME_BYTES; i++) begin
      sum = sum_step(sum, name_bytes[8*i +: 8]);
    end
  end

  always_comb begin
    chain_pending_next  = chain_pending;
    chain_checksum_next = chain_checksum;
    chain_start_next    = chain_start;
    entry_counter_next  = entry_counter + INDEX_BITS'(1);

    result.kind          = KIND_END;
    result.position      = POS_W'(entry_counter);
    result.first_cluster = 32'h0;
    result.name_valid    = 1'b0;
    result.name_orphaned = 1'b0;
    result.chain_start   = '0;
    result.ordinal       = 6'h0;
    result.name_sum      = sum;

    if (b0 == 8'h00) begin
      // end of directory: restart the index and forget any chain
      chain_pending_next  = 1'b0;
      chain_checksum_next = 8'h00;
      chain_start_next    = '0;
      entry_counter_next  = '0;
    end else if (b0 == FREE_MARK) begin
      result.kind = KIND_FREE;
    end else if ((entry.attr & LFN_MASK) == LFN_ATTR) begin
      result.ordinal = b0[5:0];
      if (b0[ORD_FIRST_BIT]) begin
        chain_pending_next  = 1'b1;
        chain_checksum_next = entry.long_cksum;
        chain_start_next    = entry_counter;
      end
      if (entry.long_cksum != chain_checksum_next) begin
        result.name_orphaned = chain_pending_next;
        chain_pending_next   = 1'b0;
      end
      result.kind = chain_pending_next ? KIND_FRAG_KEPT : KIND_FRAG_DROP;
    end else if (entry.attr == VOLUME_ATTR) begin
      result.kind = KIND_VOLUME;
    end else begin
      result.first_cluster = {entry.clus_hi, entry.clus_lo};
      result.kind          = entry.attr[DIR_BIT] ? KIND_DIR : KIND_FILE;
      if (chain_pending) begin
        if (sum == chain_checksum) begin
          result.name_valid  = 1'b1;
          result.chain_start = POS_W'(chain_start);
        end else begin
          result.name_orphaned = 1'b1;
        end
      end
      chain_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_pending  <= 1'b0;
      chain_checksum <= 8'h00;
      chain_start    <= '0;
      entry_counter  <= '0;
    end else if (take) begin
      chain_pending  <= chain_pending_next;
      chain_checksum <= chain_checksum_next;
      chain_start    <= chain_start_next;
      entry_counter  <= entry_counter_next;
    end
  end

  a_valid_orphan_excl: assert property (@(posedge clk) disable iff (rst)
    take |-> !(result.name_valid && result.name_orphaned))
    else $error("long name reported both valid and orphaned");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && result.kind == KIND_END |=> entry_counter == '0 && !chain_pending)
    else $error("end entry did not clear the scan state");

  a_short_closes_chain: assert property (@(posedge clk) disable iff (rst)
    take && (result.kind == KIND_FILE || result.kind == KIND_DIR) |=> !chain_pending)
    else $error("chain still pending after a short entry");

  a_valid_needs_chain: assert property (@(posedge clk) disable iff (rst)
    take && result.name_valid |-> chain_pending)
    else $error("long name valid without a pending chain");

  a_kept_sets_pending: assert property (@(posedge clk) disable iff (rst)
    take && result.kind == KIND_FRAG_KEPT |=> chain_pending)
    else $error("kept fragment left no pending chain");

endmodule

// ===== design/fat_dir_entry_scanner.sv =====
// ----------------------------------------------------------------------------
// fat_dir_entry_scanner: FAT directory entry classifier
// Classifies 32-byte directory entries and checks long-name chains.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one directory entry per word on s_axis_tdata.
//   Master channel: one result word per entry; entry kind on m_axis_tuser.
//   An end entry reports its index and then restarts the index at zero and
//   forgets any pending long-name chain.
//   Stages: a word accepted passes the input register, then the result
//   register (two register stages). Throughput: one entry per cycle
//   unless the receiver stalls; the name checksum is split across the
//   two stages, six name bytes before the input register and five after.
//   When the receiver stalls, the result register holds its word and the
//   input register still takes one more entry; then s_axis_tready drops
//   until the master side moves again.
//   Reset clears both valid flags, the chain state and the entry index.
// ----------------------------------------------------------------------------
module fat_dir_entry_scanner #(
  parameter int INDEX_BITS = fdes_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // name_bytes_low[63:0], name_bytes_high[87:64], attribute_byte[95:88],
  // long_checksum_byte[103:96], cluster_high_half[119:104],
  // cluster_low_half[135:120]
  input  logic [fdes_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // entry_position[15:0], first_cluster[47:16], long_name_valid[48],
  // long_name_orphaned[49], chain_start_position[65:50],
  // fragment_ordinal[71:66], short_name_checksum[79:72]
  output logic [fdes_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // entry_kind[2:0]
  output logic [fdes_pkg::KIND_W-1:0]     m_axis_tuser
);
  import fdes_pkg::*;

  entry_t  entry;
  logic    entry_valid;
  logic    take;
  result_t result;
  result_t out_word;

  // advance the held entry whenever the result register is free
  assign take = entry_valid && (!m_axis_tvalid || m_axis_tready);

  fdes_input_stage u_input (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .take          (take),
    .entry_valid   (entry_valid),
    .entry         (entry)
  );

  fdes_classifier #(
    .INDEX_BITS (INDEX_BITS)
  ) u_classifier (
    .clk    (clk),
    .rst    (rst),
    .entry  (entry),
    .take   (take),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_word <= result;
    end
  end

  assign m_axis_tuser = out_word.kind;
  assign m_axis_tdata = {out_word.name_sum, out_word.ordinal, out_word.chain_start,
                         out_word.name_orphaned, out_word.name_valid,
                         out_word.first_cluster, out_word.position};

endmodule

// ===== test/tb_fat_dir_entry_scanner.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fat_dir_entry_scanner: self-checking bench for the FAT entry scanner
// Streams directory entries into the scanner. A local classifier keeps its own
// long-name chain state and entry index and predicts every result word. Both
// stream sides idle at random. The run covers directed corner entries, random
// long-name chains with flaws and noise, and a back-to-back burst.
// ----------------------------------------------------------------------------
module tb_fat_dir_entry_scanner;
  import fdes_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ENTRIES = 1750;
  localparam int BURST_ENTRIES  = 120;

  localparam logic [7:0]  END_MARK      = 8'h00;
  localparam logic [7:0]  DIR_FLAG_ATTR = 8'(1 << DIR_BIT);
  localparam logic [63:0] SHORT_LO      = 64'h2020_3154_5245_504F;
  localparam logic [23:0] SHORT_HI      = 24'h474643;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [KIND_W-1:0]     m_axis_tuser;

  // classifier state
  logic        lfn_open  = 1'b0;
  logic [7:0]  lfn_cksum = '0;
  logic [15:0] lfn_start = '0;
  logic [15:0] dir_index = '0;

  result_t entry_reports[$];
  int      mismatch_count = 0;
  int      idle_cycles    = 0;
  int      entries_sent   = 0;
  bit      src_quiet      = 1'b0;
  bit      snk_quiet      = 1'b0;

  fat_dir_entry_scanner dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic logic [23:0] rand24();
    return 24'($urandom);
  endfunction

  function automatic logic [7:0] short_name_sum(input logic [63:0] lo, input logic [23:0] hi);
    logic [87:0] name;
    logic [7:0]  acc;
    name = {hi, lo};
    acc  = '0;
    for (int i = 0; i < SHORT_NAME_BYTES; i++) acc = {acc[0], acc[7:1]} + name[8*i +: 8];
    return acc;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_entry(
    input logic [63:0] lo, input logic [23:0] hi, input logic [7:0] attr,
    input logic [7:0] lcs, input logic [15:0] clus_hi, input logic [15:0] clus_lo);
    return {clus_lo, clus_hi, lcs, attr, hi, lo};
  endfunction

  // random name bytes behind a chosen leading byte
  function automatic logic [63:0] with_lead(input logic [7:0] lead);
    logic [63:0] v;
    v      = {$urandom, $urandom};
    v[7:0] = lead;
    return v;
  endfunction

  function automatic int draw_wait(input bit quiet);
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic classify_entry(input logic [IN_DATA_W-1:0] w);
    result_t     r;
    logic [63:0] lo;
    logic [23:0] hi;
    logic [7:0]  attr;
    logic [7:0]  lcs;
    logic [7:0]  lead;
    lo   = w[63:0];
    hi   = w[87:64];
    attr = w[95:88];
    lcs  = w[103:96];
    lead = lo[7:0];
    r          = '0;
    r.position = dir_index;
    r.name_sum = short_name_sum(lo, hi);
    if (lead == END_MARK) begin
      r.kind    = KIND_END;
      lfn_open  = 1'b0;
      lfn_cksum = '0;
      lfn_start = '0;
      dir_index = '0;
    end else begin
      if (lead == FREE_MARK) begin
        r.kind = KIND_FREE;
      end else if ((attr & LFN_MASK) == LFN_ATTR) begin
        r.ordinal = lead[5:0];
        if (lead[ORD_FIRST_BIT]) begin
          lfn_open  = 1'b1;
          lfn_cksum = lcs;
          lfn_start = dir_index;
        end
        // compare after any restart, so a fresh start always matches itself
        if (lcs != lfn_cksum) begin
          r.name_orphaned = lfn_open;
          lfn_open        = 1'b0;
        end
        r.kind = lfn_open ? KIND_FRAG_KEPT : KIND_FRAG_DROP;
      end else if (attr == VOLUME_ATTR) begin
        r.kind = KIND_VOLUME;
      end else begin
        r.first_cluster = {w[119:104], w[135:120]};
        r.kind          = attr[DIR_BIT] ? KIND_DIR : KIND_FILE;
        if (lfn_open) begin
          if (r.name_sum == lfn_cksum) begin
            r.name_valid  = 1'b1;
            r.chain_start = lfn_start;
          end else begin
            r.name_orphaned = 1'b1;
          end
        end
        lfn_open = 1'b0;
      end
      dir_index = dir_index + 16'd1;
    end
    entry_reports.push_back(r);
  endtask

  task automatic send_entry(input logic [IN_DATA_W-1:0] w);
    int gap;
    gap = draw_wait(src_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
    classify_entry(w);
    entries_sent++;
  endtask

  // park the sender and hold until every predicted word has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (entry_reports.size() != 0) @(posedge clk);
  endtask

  task automatic send_noise();
    logic [63:0] lo;
    logic [7:0]  attr;
    lo   = {$urandom, $urandom};
    attr = rand8();
    if ($urandom_range(0, 3) == 0) attr[5:0] = LFN_ATTR[5:0];
    if ($urandom_range(0, 7) == 0) lo[7:0] = FREE_MARK;
    send_entry(pack_entry(lo, rand24(), attr, rand8(), rand16(), rand16()));
  endtask

  // one long-name chain followed by its short entry, an end entry or a volume label, sometimes with a flaw
  task automatic send_chain();
    logic [63:0] lo;
    logic [23:0] hi;
    logic [7:0]  cs;
    logic [7:0]  attr;
    logic [7:0]  lead;
    logic [7:0]  lcs;
    int          n;
    int          flaw;
    lo = {$urandom, $urandom};
    while (lo[7:0] == END_MARK || lo[7:0] == FREE_MARK) lo[7:0] = rand8();
    hi   = rand24();
    cs   = short_name_sum(lo, hi);
    n    = $urandom_range(1, 4);
    flaw = $urandom_range(0, 9);
    for (int k = n; k >= 1; k--) begin
      if (k == n && flaw == 2) continue;   // lose the opening fragment
      lead    = 8'(k);
      lead[7] = 1'($urandom_range(0, 1));
      if (k == n) lead[ORD_FIRST_BIT] = 1'b1;
      lcs = cs;
      if (flaw == 0) lcs = cs ^ 8'h01;
      if (flaw == 1 && k == 1) lcs = cs ^ 8'($urandom_range(1, 255));
      attr      = LFN_ATTR;
      attr[7:6] = 2'($urandom_range(0, 3));
      send_entry(pack_entry(with_lead(lead), rand24(), attr, lcs, rand16(), rand16()));
      if ($urandom_range(0, 9) == 0)
        send_entry(pack_entry(with_lead(FREE_MARK), rand24(), rand8(), rand8(),
                              rand16(), rand16()));
      else if ($urandom_range(0, 14) == 0)
        send_entry(pack_entry(lo, hi, VOLUME_ATTR, rand8(), rand16(), rand16()));
    end
    case ($urandom_range(0, 14))
      0: begin
        send_entry(pack_entry(with_lead(END_MARK), hi, rand8(), cs, rand16(), rand16()));
      end
      1: begin
        send_entry(pack_entry(lo, hi, VOLUME_ATTR, cs, rand16(), rand16()));
      end
      default: begin
        attr = rand8();
        while ((attr & LFN_MASK) == LFN_ATTR || attr == VOLUME_ATTR) attr = rand8();
        send_entry(pack_entry(lo, hi, attr, rand8(), rand16(), rand16()));
      end
    endcase
  endtask

  task automatic test_directed();
    logic [7:0] cs;
    cs = short_name_sum(SHORT_LO, SHORT_HI);
    send_entry(pack_entry({{56{1'b1}}, END_MARK}, '1, '1, '1, '1, '1));
    send_entry(pack_entry({{56{1'b1}}, FREE_MARK}, '1, '1, '1, '1, '1));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, VOLUME_ATTR, 8'h00, '1, '1));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, VOLUME_ATTR | 8'h40, 8'h00, '1, '1));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, DIR_FLAG_ATTR, 8'h00, '1, '1));
    send_entry(pack_entry('1, '1, 8'h00, 8'hFF, '0, '0));
    // clean chain with a free entry and a volume label inside it
    send_entry(pack_entry(with_lead(8'h42), 24'h123456, LFN_ATTR, cs, 16'h1111, 16'h2222));
    send_entry(pack_entry(with_lead(FREE_MARK), 24'h0, LFN_ATTR, 8'h00, 16'h0, 16'h0));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, VOLUME_ATTR, cs, 16'h0, 16'h0));
    send_entry(pack_entry(with_lead(8'h01), 24'hABCDEF, LFN_ATTR | 8'hC0, cs, 16'h0, 16'h0));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, 8'h20, 8'h00, 16'hDEAD, 16'hBEEF));
    // stray fragment, then a chain broken by a bad checksum
    send_entry(pack_entry(with_lead(8'h01), 24'h0, LFN_ATTR, cs, 16'h0, 16'h0));
    send_entry(pack_entry(with_lead(8'h41), 24'h0, LFN_ATTR, cs, 16'h0, 16'h0));
    send_entry(pack_entry(with_lead(8'h01), 24'h0, LFN_ATTR, cs ^ 8'h01, 16'h0, 16'h0));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, DIR_FLAG_ATTR, 8'h00, 16'h0001, 16'h0002));
    // chain that does not belong to the short name
    send_entry(pack_entry(with_lead(8'h41), 24'h0, LFN_ATTR, cs ^ 8'h80, 16'h0, 16'h0));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, DIR_FLAG_ATTR | 8'h01, 8'h00, 16'hFFFF,
                          16'h0000));
    // restarted chain, then an end entry drops it and rewinds the index
    send_entry(pack_entry(with_lead(8'h7F), 24'h0, LFN_ATTR, 8'hAA, 16'h0, 16'h0));
    send_entry(pack_entry(with_lead(8'h43), 24'h0, LFN_ATTR, 8'hBB, 16'h0, 16'h0));
    send_entry(pack_entry(with_lead(END_MARK), 24'h0, LFN_ATTR, 8'hBB, 16'h0, 16'h0));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, 8'h00, 8'hBB, 16'h0, 16'hFFFF));
    send_entry(pack_entry(with_lead(8'hFF), 24'hFFFFFF, LFN_ATTR | 8'h80, cs, '1, '1));
    send_entry(pack_entry(SHORT_LO, SHORT_HI, 8'h01, cs, 16'h0F0F, 16'hF0F0));
    drain_results();
  endtask

  task automatic test_long_name_chains();
    int goal;
    int halfway;
    bit paused;
    goal    = entries_sent + RANDOM_ENTRIES;
    halfway = entries_sent + RANDOM_ENTRIES / 2;
    paused  = 1'b0;
    while (entries_sent < goal) begin
      src_quiet = ($urandom_range(0, 7) == 0);
      snk_quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 4) == 0) send_noise();
      else send_chain();
      if (!paused && entries_sent >= halfway) begin
        drain_results();
        paused = 1'b1;
      end
    end
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
  endtask

  // back-to-back entries with no end entry
  task automatic test_back_to_back();
    logic [63:0] lo;
    src_quiet = 1'b1;
    snk_quiet = 1'b1;
    repeat (BURST_ENTRIES) begin
      lo = {$urandom, $urandom};
      if (lo[7:0] == END_MARK) lo[7:0] = FREE_MARK;
      send_entry(pack_entry(lo, rand24(), rand8(), rand8(), rand16(), rand16()));
    end
    src_quiet = 1'b0;
    snk_quiet = 1'b0;
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (entry_reports.size() == 0) begin
        $display("%0t: result word with no entry waiting, expected none, actual %h / %h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = entry_reports.pop_front();
        check_field("entry_kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("entry_position", 32'(want.position), 32'(m_axis_tdata[15:0]));
        check_field("first_cluster", want.first_cluster, m_axis_tdata[47:16]);
        check_field("long_name_valid", 32'(want.name_valid), 32'(m_axis_tdata[48]));
        check_field("long_name_orphaned", 32'(want.name_orphaned), 32'(m_axis_tdata[49]));
        check_field("chain_start_position", 32'(want.chain_start),
                    32'(m_axis_tdata[65:50]));
        check_field("fragment_ordinal", 32'(want.ordinal), 32'(m_axis_tdata[71:66]));
        check_field("short_name_checksum", 32'(want.name_sum), 32'(m_axis_tdata[79:72]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // result receiver: random stalls per word
  initial begin
    int gap;
    wait (rst == 1'b0);
    forever begin
      gap = draw_wait(snk_quiet);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_name_chains();
    test_back_to_back();
    drain_results();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && entry_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
